### hw/rtl/mxyrc_pkg.sv
// ----------------------------------------------------------------------------
// mxyrc_pkg - shared types and constants of the mesh XY route model
// Register indexes, request and command types, sizing constants.
// ----------------------------------------------------------------------------
package mxyrc_pkg;

    localparam int MaxNodes     = 64;
    localparam int QueueDepth   = 16;
    localparam int CongestLimit = 10;
    localparam int NodeW        = 6;
    localparam int SlotW        = 4;
    localparam int CntW         = 5;
    localparam int QueueAw      = NodeW + SlotW;

    // register indexes
    localparam logic [1:0] REG_LINK_LAT = 2'd0;
    localparam logic [1:0] REG_WIDTH    = 2'd1;
    localparam logic [1:0] REG_NODES    = 2'd2;

    typedef enum logic [0:0] {
        FUNC_SEND = 1'b0,
        FUNC_RECV = 1'b1
    } t_func;

    // classified command handed from front to back
    typedef struct packed {
        t_func       func;
        logic        err;
        logic [5:0]  src;
        logic [5:0]  dst;
        logic [7:0]  hops;
        logic [6:0]  x;
        logic [6:0]  y;
        logic [6:0]  dx;
        logic [6:0]  dy;
        logic [6:0]  w;
    } t_cmd;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WALK,
        ST_RMW,
        ST_QUEUE,
        ST_DONE
    } t_state;

endpackage

### hw/rtl/mxyrc_front.sv
// ----------------------------------------------------------------------------
// mxyrc_front - request intake and classification
// Checks node ids, splits a valid send's source and destination into column
// and row, one quotient bit per cycle, then offers the command to the queue.
// ----------------------------------------------------------------------------
module mxyrc_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_func,
    input  logic [5:0]         i_source_node,
    input  logic [5:0]         i_dest_node,
    input  logic [7:0]         i_hop_count_in,
    input  logic [6:0]         i_mesh_width,
    input  logic [6:0]         i_num_nodes,
    output logic               o_cmd_valid,
    input  logic               i_cmd_ready,
    output mxyrc_pkg::t_cmd    o_cmd
);

    logic            r_busy, n_busy;
    logic            r_done, n_done;
    logic [2:0]      r_bit, n_bit;
    mxyrc_pkg::t_cmd r_cmd, n_cmd;
    logic [6:0]      r_rs, n_rs;     // source remainder
    logic [6:0]      r_rd, n_rd;     // destination remainder
    logic [7:0]      ts, td;
    logic [6:0]      w;

    assign o_ready     = !r_busy;
    assign o_cmd_valid = r_busy && r_done;
    assign o_cmd       = r_cmd;
    assign w           = (i_mesh_width == 7'd0) ? 7'd1 : i_mesh_width;

    // restoring division, bit r_bit of the quotient per cycle
    assign ts = {r_rs, r_cmd.src[r_bit]};
    assign td = {r_rd, r_cmd.dst[r_bit]};

    always_comb begin
        n_busy = r_busy;
        n_done = r_done;
        n_bit  = r_bit;
        n_cmd  = r_cmd;
        n_rs   = r_rs;
        n_rd   = r_rd;
        if (!r_busy) begin
            if (i_valid) begin
                n_busy     = 1'b1;
                n_bit      = 3'd5;
                n_rs       = '0;
                n_rd       = '0;
                n_cmd      = '0;
                n_cmd.func = mxyrc_pkg::t_func'(i_func);
                n_cmd.src  = i_source_node;
                n_cmd.dst  = i_dest_node;
                n_cmd.hops = i_hop_count_in;
                n_cmd.w    = w;
                n_cmd.err  = ({1'b0, i_dest_node} >= i_num_nodes) ||
                             ((i_func == 1'b0) && ({1'b0, i_source_node} >= i_num_nodes));
                n_done     = (i_func == 1'b1) || n_cmd.err;
            end
        end else if (!r_done) begin
            if (ts >= {1'b0, r_cmd.w}) begin
                n_rs = 7'(ts - {1'b0, r_cmd.w});
                n_cmd.y[r_bit] = 1'b1;
            end else begin
                n_rs = ts[6:0];
            end
            if (td >= {1'b0, r_cmd.w}) begin
                n_rd = 7'(td - {1'b0, r_cmd.w});
                n_cmd.dy[r_bit] = 1'b1;
            end else begin
                n_rd = td[6:0];
            end
            if (r_bit == 3'd0) begin
                n_done   = 1'b1;
                n_cmd.x  = n_rs;
                n_cmd.dx = n_rd;
            end
            n_bit = r_bit - 3'd1;
        end else if (i_cmd_ready) begin
            n_busy = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_bit  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_bit  <= n_bit;
        end
        r_cmd <= n_cmd;
        r_rs  <= n_rs;
        r_rd  <= n_rd;
    end

endmodule

### hw/rtl/mxyrc_cmdq.sv
// ----------------------------------------------------------------------------
// mxyrc_cmdq - two-entry command queue between front and back
// Lets classification of the next request run while a walk is under way.
// ----------------------------------------------------------------------------
module mxyrc_cmdq (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  mxyrc_pkg::t_cmd    i_cmd,
    output logic               o_valid,
    input  logic               i_ready,
    output mxyrc_pkg::t_cmd    o_cmd
);

    mxyrc_pkg::t_cmd r_mem [2];
    logic            r_wp, r_rp;
    logic [1:0]      r_cnt;
    logic            push, pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_cmd   = r_mem[r_rp];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    // pointers and fill
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (push) r_wp <= !r_wp;
            if (pop)  r_rp <= !r_rp;
            r_cnt <= 2'(r_cnt + {1'b0, push} - {1'b0, pop});
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wp] <= i_cmd;
    end

endmodule

### hw/rtl/mxyrc_back.sv
// ----------------------------------------------------------------------------
// mxyrc_back - route walk, node queues and result register
// Walks the XY route of a send hop by hop (counter read, then update), then
// pushes (send) or pops (receive) the node queue and registers the result.
// ----------------------------------------------------------------------------
module mxyrc_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cmd_valid,
    output logic               o_cmd_ready,
    input  mxyrc_pkg::t_cmd    i_cmd,
    input  logic [7:0]         i_link_latency,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [15:0]        o_latency,
    output logic [6:0]         o_congested_hops,
    output logic               o_node_error,
    output logic               o_dropped,
    output logic               o_recv_valid,
    output logic [5:0]         o_recv_source,
    output logic [7:0]         o_recv_hops,
    output logic [4:0]         o_pending_after
);

    mxyrc_pkg::t_state r_state, n_state;
    mxyrc_pkg::t_cmd   r_cmd;

    // congestion counters with per-node valid bits
    logic [7:0]  r_cong [mxyrc_pkg::MaxNodes];
    logic [mxyrc_pkg::MaxNodes-1:0] r_cval;
    logic [mxyrc_pkg::SlotW-1:0] r_head [mxyrc_pkg::MaxNodes];
    logic [mxyrc_pkg::CntW-1:0]  r_qcnt [mxyrc_pkg::MaxNodes];
    logic [mxyrc_pkg::MaxNodes-1:0] r_qval;
    logic [13:0] r_qmem [2**mxyrc_pkg::QueueAw];     // {source, hops}
    logic [13:0] r_qrd;

    logic [16:0] r_lat;
    logic [6:0]  r_chops;
    logic [12:0] r_node;              // current walk node id, at most 125
    logic [7:0]  r_cur;               // counter value read
    logic        r_ob_v;
    logic [15:0] r_lat_o;
    logic [6:0]  r_ch_o;
    logic        r_err_o, r_drop_o, r_rv_o;
    logic [5:0]  r_rs_o;
    logic [7:0]  r_rh_o;
    logic [4:0]  r_pd_o;

    logic [5:0]  nid;
    logic        in_store, at_dest, xmove;
    logic [7:0]  cv;
    logic [4:0]  qc;
    logic [3:0]  hd;
    logic        dvalid;

    assign nid      = r_node[5:0];
    assign in_store = (r_node < 13'(mxyrc_pkg::MaxNodes));
    assign xmove    = (r_cmd.x != r_cmd.dx);
    assign at_dest  = !xmove && (r_cmd.y == r_cmd.dy);
    assign dvalid   = r_qval[r_cmd.dst];
    assign qc       = dvalid ? r_qcnt[r_cmd.dst] : '0;
    assign hd       = dvalid ? r_head[r_cmd.dst] : '0;
    assign cv       = r_cval[nid] ? r_cong[nid] : '0;

    assign o_cmd_ready = (r_state == mxyrc_pkg::ST_IDLE) && !r_ob_v;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            mxyrc_pkg::ST_IDLE:
                if (i_cmd_valid && !r_ob_v) begin
                    if (i_cmd.err) n_state = mxyrc_pkg::ST_DONE;
                    else if (i_cmd.func == mxyrc_pkg::FUNC_RECV)
                        n_state = mxyrc_pkg::ST_QUEUE;
                    else n_state = mxyrc_pkg::ST_WALK;
                end
            mxyrc_pkg::ST_WALK:
                n_state = at_dest ? mxyrc_pkg::ST_QUEUE : mxyrc_pkg::ST_RMW;
            mxyrc_pkg::ST_RMW:   n_state = mxyrc_pkg::ST_WALK;
            mxyrc_pkg::ST_QUEUE: n_state = mxyrc_pkg::ST_DONE;
            mxyrc_pkg::ST_DONE:  n_state = mxyrc_pkg::ST_IDLE;
            default:             n_state = mxyrc_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= mxyrc_pkg::ST_IDLE;
        else          r_state <= n_state;
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cval <= '0;
            r_qval <= '0;
            r_ob_v <= 1'b0;
        end else begin
            if (r_ob_v && i_ready) r_ob_v <= 1'b0;
            case (r_state)
                mxyrc_pkg::ST_IDLE: begin
                    if (i_cmd_valid && !r_ob_v) begin
                        r_cmd   <= i_cmd;
                        r_lat   <= '0;
                        r_chops <= '0;
                        r_node  <= 13'(i_cmd.src);
                        r_rv_o  <= 1'b0;
                        r_rs_o  <= '0;
                        r_rh_o  <= '0;
                        r_drop_o <= 1'b0;
                        r_pd_o  <= '0;
                    end
                end
                mxyrc_pkg::ST_WALK: begin
                    r_cur <= cv;
                end
                mxyrc_pkg::ST_RMW: begin
                    // the sum stays far below the 17-bit range
                    if (in_store && r_cur > 8'(mxyrc_pkg::CongestLimit)) begin
                        r_lat   <= 17'(r_lat + {i_link_latency, 1'b0});
                        r_chops <= 7'(r_chops + 7'd1);
                    end else begin
                        r_lat <= 17'(r_lat + {9'd0, i_link_latency});
                    end
                    if (in_store) begin
                        r_cval[nid] <= 1'b1;
                        r_cong[nid] <= (r_cur == 8'hFF) ? r_cur : 8'(r_cur + 8'd1);
                    end
                    if (r_cmd.hops != 8'hFF) r_cmd.hops <= 8'(r_cmd.hops + 8'd1);
                    if (xmove) begin
                        if (r_cmd.x < r_cmd.dx) begin
                            r_cmd.x <= 7'(r_cmd.x + 7'd1);
                            r_node  <= 13'(r_node + 13'd1);
                        end else begin
                            r_cmd.x <= 7'(r_cmd.x - 7'd1);
                            r_node  <= 13'(r_node - 13'd1);
                        end
                    end else if (r_cmd.y < r_cmd.dy) begin
                        r_cmd.y <= 7'(r_cmd.y + 7'd1);
                        r_node  <= 13'(r_node + {6'd0, r_cmd.w});
                    end else begin
                        r_cmd.y <= 7'(r_cmd.y - 7'd1);
                        r_node  <= 13'(r_node - {6'd0, r_cmd.w});
                    end
                end
                mxyrc_pkg::ST_QUEUE: begin
                    r_qval[r_cmd.dst] <= 1'b1;
                    if (r_cmd.func == mxyrc_pkg::FUNC_SEND) begin
                        r_head[r_cmd.dst] <= hd;
                        if (qc >= 5'(mxyrc_pkg::QueueDepth)) begin
                            r_drop_o          <= 1'b1;
                            r_qcnt[r_cmd.dst] <= qc;
                            r_pd_o            <= qc;
                        end else begin
                            r_qcnt[r_cmd.dst] <= 5'(qc + 5'd1);
                            r_pd_o            <= 5'(qc + 5'd1);
                        end
                    end else if (qc != 5'd0) begin
                        r_rv_o <= 1'b1;
                        r_head[r_cmd.dst] <= 4'(hd + 4'd1);
                        r_qcnt[r_cmd.dst] <= 5'(qc - 5'd1);
                        r_pd_o <= 5'(qc - 5'd1);
                        if (r_cval[r_cmd.dst] && r_cong[r_cmd.dst] != 8'd0)
                            r_cong[r_cmd.dst] <= 8'(r_cong[r_cmd.dst] - 8'd1);
                    end else begin
                        r_head[r_cmd.dst] <= hd;
                        r_qcnt[r_cmd.dst] <= qc;
                        r_pd_o            <= qc;
                    end
                end
                mxyrc_pkg::ST_DONE: begin
                    r_ob_v  <= 1'b1;
                    r_err_o <= r_cmd.err;
                    r_ch_o  <= r_cmd.err ? 7'd0 : r_chops;
                    r_lat_o <= r_cmd.err ? 16'd0 :
                               (r_lat[16] ? 16'hFFFF : r_lat[15:0]);
                    if (r_cmd.err) begin
                        r_pd_o <= '0;
                        r_rv_o <= 1'b0;
                    end
                    r_rs_o <= r_rv_o ? r_qrd[13:8] : 6'd0;
                    r_rh_o <= r_rv_o ? r_qrd[7:0]  : 8'd0;
                end
                default: ;
            endcase
        end
    end

    // node queue memory: write on push, registered read at the head
    always_ff @(posedge i_clk) begin
        if (r_state == mxyrc_pkg::ST_QUEUE) begin
            if (r_cmd.func == mxyrc_pkg::FUNC_SEND &&
                qc < 5'(mxyrc_pkg::QueueDepth))
                r_qmem[{r_cmd.dst, 4'(hd + qc[3:0])}] <= {r_cmd.src, r_cmd.hops};
            r_qrd <= r_qmem[{r_cmd.dst, hd}];
        end
    end

    assign o_valid          = r_ob_v;
    assign o_latency        = r_lat_o;
    assign o_congested_hops = r_ch_o;
    assign o_node_error     = r_err_o;
    assign o_dropped        = r_drop_o;
    assign o_recv_valid     = r_rv_o;
    assign o_recv_source    = r_rs_o;
    assign o_recv_hops      = r_rh_o;
    assign o_pending_after  = r_pd_o;

endmodule

### hw/rtl/mesh_xy_route_congestion.sv
// Flow: the front end checks node ids and splits a valid send's source and
// destination into column and row; the back end walks a send's route with
// one counter read-modify-write per hop, then steps the node queue for sends
// and receives and registers the result; hops at most (width-1)+(rows-1).
// The back end takes a new command only when idle with no result waiting;
// the front end classifies the next transaction meanwhile.
// Reset (synchronous, active low) clears control state and valid bits;
// no clearing pass is needed.
// ----------------------------------------------------------------------------
// mesh_xy_route_congestion - XY mesh route latency and delivery model
// Front classifies, a short queue decouples, back walks routes and queues.
// ----------------------------------------------------------------------------
module mesh_xy_route_congestion (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_func,
    input  logic [5:0]  i_source_node,
    input  logic [5:0]  i_dest_node,
    input  logic [7:0]  i_hop_count_in,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [15:0] o_latency,
    output logic [6:0]  o_congested_hops,
    output logic        o_node_error,
    output logic        o_dropped,
    output logic        o_recv_valid,
    output logic [5:0]  o_recv_source,
    output logic [7:0]  o_recv_hops,
    output logic [4:0]  o_pending_after,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data
);

    logic [7:0] r_link_lat;
    logic [6:0] r_mesh_w;
    logic [6:0] r_num_nodes;
    logic            f_v, f_r, b_v, b_r;
    mxyrc_pkg::t_cmd f_cmd, b_cmd;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link_lat  <= 8'd1;
            r_mesh_w    <= 7'd8;
            r_num_nodes <= 7'd64;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                mxyrc_pkg::REG_LINK_LAT: r_link_lat  <= i_cfg_data;
                mxyrc_pkg::REG_WIDTH:    r_mesh_w    <= i_cfg_data[6:0];
                mxyrc_pkg::REG_NODES:    r_num_nodes <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    mxyrc_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_ready,
        .i_func, .i_source_node, .i_dest_node, .i_hop_count_in,
        .i_mesh_width (r_mesh_w),
        .i_num_nodes  (r_num_nodes),
        .o_cmd_valid  (f_v),
        .i_cmd_ready  (f_r),
        .o_cmd        (f_cmd)
    );

    mxyrc_cmdq u_cmdq (
        .i_clk, .i_rst_n,
        .i_valid (f_v), .o_ready (f_r), .i_cmd (f_cmd),
        .o_valid (b_v), .i_ready (b_r), .o_cmd (b_cmd)
    );

    mxyrc_back u_back (
        .i_clk, .i_rst_n,
        .i_cmd_valid (b_v), .o_cmd_ready (b_r), .i_cmd (b_cmd),
        .i_link_latency (r_link_lat),
        .o_valid, .i_ready,
        .o_latency, .o_congested_hops, .o_node_error, .o_dropped,
        .o_recv_valid, .o_recv_source, .o_recv_hops, .o_pending_after
    );

endmodule

### sim/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top - self-checking bench for the XY mesh route latency model
// Drives send and receive transactions through the valid/ready port, predicts
// route latency, congestion penalties and per-node message queues, and checks
// every result in order. Several mesh configurations are exercised.
// ----------------------------------------------------------------------------
module tb_top;

    typedef struct packed {
        logic [15:0] latency;
        logic [6:0]  cong_hops;
        logic        node_err;
        logic        dropped;
        logic        rvalid;
        logic [5:0]  rsrc;
        logic [7:0]  rhops;
        logic [4:0]  pending;
    } t_route_res;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic        i_func = 1'b0;
    logic [5:0]  i_source_node = '0;
    logic [5:0]  i_dest_node = '0;
    logic [7:0]  i_hop_count_in = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [15:0] o_latency;
    logic [6:0]  o_congested_hops;
    logic        o_node_error;
    logic        o_dropped;
    logic        o_recv_valid;
    logic [5:0]  o_recv_source;
    logic [7:0]  o_recv_hops;
    logic [4:0]  o_pending_after;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_index = '0;
    logic [7:0]  i_cfg_data = '0;

    mesh_xy_route_congestion uut (.*);

    always #6 i_clk = ~i_clk;

    // predictor state
    logic [7:0]  lat_cfg;
    logic [6:0]  width_cfg;
    logic [6:0]  nodes_cfg;
    logic [7:0]  cong_lvl [mxyrc_pkg::MaxNodes];
    logic [5:0]  q_src [mxyrc_pkg::MaxNodes][mxyrc_pkg::QueueDepth];
    logic [7:0]  q_hops [mxyrc_pkg::MaxNodes][mxyrc_pkg::QueueDepth];
    logic [3:0]  q_head [mxyrc_pkg::MaxNodes];
    logic [4:0]  q_cnt [mxyrc_pkg::MaxNodes];

    t_route_res  expected_q [$];
    int          err_count = 0;
    int          idle_cycles = 0;
    bit          bursty = 1'b1;
    bit          hold_rx = 1'b0;
    int          burst_max = 18;

    task automatic report(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        err_count++;
    endtask

    function automatic bit node_ok(input int id);
        return id < nodes_cfg && id < mxyrc_pkg::MaxNodes;
    endfunction

    // walk the XY route, update queues, return the expected result
    function automatic t_route_res route_predict(input mxyrc_pkg::t_func f,
                                                 input int src, input int dst,
                                                 input int hops);
        t_route_res r;
        int w, x, y, dx, dy, id, lat, cong, slot;
        r = '0;
        lat = 0;
        cong = 0;
        if (f == mxyrc_pkg::FUNC_SEND) begin
            if (!node_ok(src) || !node_ok(dst)) begin
                r.node_err = 1'b1;
                return r;
            end
            w = (width_cfg == 0) ? 1 : width_cfg;
            x = src % w; y = src / w; dx = dst % w; dy = dst / w;
            while (x != dx || y != dy) begin
                id = y * w + x;
                if (id < mxyrc_pkg::MaxNodes) begin
                    if (cong_lvl[id] > mxyrc_pkg::CongestLimit) begin
                        lat += 2 * lat_cfg;
                        cong++;
                    end else begin
                        lat += lat_cfg;
                    end
                    if (cong_lvl[id] < 255) cong_lvl[id]++;
                end else begin
                    lat += lat_cfg;
                end
                if (x != dx) x = (x < dx) ? x + 1 : x - 1;
                else y = (y < dy) ? y + 1 : y - 1;
                if (hops < 255) hops++;
            end
            if (q_cnt[dst] >= mxyrc_pkg::QueueDepth) begin
                r.dropped = 1'b1;
            end else begin
                slot = (q_head[dst] + q_cnt[dst]) % mxyrc_pkg::QueueDepth;
                q_src[dst][slot] = 6'(src);
                q_hops[dst][slot] = 8'(hops);
                q_cnt[dst]++;
            end
            r.pending = q_cnt[dst];
            r.latency = (lat > 65535) ? 16'hFFFF : 16'(lat);
            r.cong_hops = 7'(cong);
        end else begin
            if (!node_ok(dst)) begin
                r.node_err = 1'b1;
                return r;
            end
            if (q_cnt[dst] > 0) begin
                r.rvalid = 1'b1;
                r.rsrc = q_src[dst][q_head[dst]];
                r.rhops = q_hops[dst][q_head[dst]];
                q_head[dst]++;
                q_cnt[dst]--;
                if (cong_lvl[dst] > 0) cong_lvl[dst]--;
            end
            r.pending = q_cnt[dst];
        end
        return r;
    endfunction

    // send one transaction and queue its prediction at acceptance;
    // valid stays high so the next call can follow without a gap
    task automatic send_item(input mxyrc_pkg::t_func f, input int src, input int dst,
                             input int hops);
        int gap;
        t_route_res pred;
        if (bursty && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, burst_max);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_func <= f;
        i_source_node <= 6'(src);
        i_dest_node <= 6'(dst);
        i_hop_count_in <= 8'(hops);
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        pred = route_predict(f, src, dst, hops);
        expected_q = {expected_q, pred};
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input int val);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= 8'(val);
        @(posedge i_clk);
        case (idx)
            mxyrc_pkg::REG_LINK_LAT: lat_cfg = 8'(val);
            mxyrc_pkg::REG_WIDTH:    width_cfg = 7'(val);
            mxyrc_pkg::REG_NODES:    nodes_cfg = 7'(val);
            default: ;
        endcase
    endtask

    task automatic set_mesh(input int lat, input int w, input int n);
        drain();
        write_reg(mxyrc_pkg::REG_LINK_LAT, lat);
        write_reg(mxyrc_pkg::REG_WIDTH, w);
        write_reg(mxyrc_pkg::REG_NODES, n);
        i_cfg_we <= 1'b0;
    endtask

    // receiver side: random stalls, or a long hold when asked
    always @(posedge i_clk) begin
        if (hold_rx) begin
            i_ready <= 1'b0;
        end else if (bursty && $urandom_range(0, 5) == 0) begin
            i_ready <= 1'b0;
            idle_cycles = $urandom_range(1, burst_max);
        end else if (idle_cycles > 0) begin
            idle_cycles--;
            i_ready <= (idle_cycles == 0);
        end else begin
            i_ready <= 1'b1;
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_route_res w;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_q.size() == 0) begin
                report("unexpected result", 0, 0);
            end else begin
                w = expected_q.pop_front();
                if (o_latency !== w.latency) report("latency", o_latency, w.latency);
                if (o_congested_hops !== w.cong_hops)
                    report("congested_hops", o_congested_hops, w.cong_hops);
                if (o_node_error !== w.node_err)
                    report("node_error", o_node_error, w.node_err);
                if (o_dropped !== w.dropped) report("dropped", o_dropped, w.dropped);
                if (o_recv_valid !== w.rvalid)
                    report("recv_valid", o_recv_valid, w.rvalid);
                if (o_recv_source !== w.rsrc)
                    report("recv_source", o_recv_source, w.rsrc);
                if (o_recv_hops !== w.rhops) report("recv_hops", o_recv_hops, w.rhops);
                if (o_pending_after !== w.pending)
                    report("pending_after", o_pending_after, w.pending);
            end
        end
    end

    // watchdog on cycles with no transaction
    int stuck = 0;
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) stuck <= 0;
        else stuck <= stuck + 1;
        if (stuck > 20000) begin
            $display("status: fail");
            $finish;
        end
    end

    // random send; well-formed sends onto valid nodes mostly
    task automatic rand_send(input int n);
        int s, d;
        s = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63) : $urandom_range(0, n - 1);
        d = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63) : $urandom_range(0, n - 1);
        send_item(mxyrc_pkg::FUNC_SEND, s, d, $urandom_range(0, 255));
    endtask

    task automatic test_directed();
        send_item(mxyrc_pkg::FUNC_RECV, 0, 5, 0);          // empty queue
        send_item(mxyrc_pkg::FUNC_SEND, 0, 63, 0);         // corner to corner
        send_item(mxyrc_pkg::FUNC_SEND, 63, 0, 255);       // hop count saturation
        send_item(mxyrc_pkg::FUNC_SEND, 9, 9, 7);          // same source and destination
        send_item(mxyrc_pkg::FUNC_RECV, 0, 63, 0);
        send_item(mxyrc_pkg::FUNC_RECV, 0, 0, 0);
        send_item(mxyrc_pkg::FUNC_RECV, 0, 9, 0);
        // congest node 0's row to pass the limit, then fill a queue
        repeat (18) send_item(mxyrc_pkg::FUNC_SEND, 0, 7, 1);
        set_mesh(255, 8, 63);                   // invalid node id 63
        send_item(mxyrc_pkg::FUNC_SEND, 63, 0, 0);
        send_item(mxyrc_pkg::FUNC_SEND, 0, 63, 0);
        send_item(mxyrc_pkg::FUNC_RECV, 0, 63, 0);
        send_item(mxyrc_pkg::FUNC_SEND, 0, 62, 3);
    endtask

    task automatic test_random(input int count, input int n);
        repeat (count) begin
            if ($urandom_range(0, 2) == 0)
                send_item(mxyrc_pkg::FUNC_RECV, $urandom_range(0, 63),
                          ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63)
                                                      : $urandom_range(0, n - 1), 0);
            else
                rand_send(n);
        end
    endtask

    task automatic test_configs();
        set_mesh(0, 0, 40);     // zero width treated as one column
        test_random(150, 40);
        set_mesh(200, 64, 64);  // one wide row
        test_random(150, 64);
        set_mesh(7, 5, 23);     // partial last row
        test_random(150, 23);
        set_mesh(255, 127, 1);  // single node, widest register value
        test_random(60, 1);
        set_mesh(3, 40, 64);
        test_random(150, 64);
        set_mesh(1, 1, 127);
        test_random(100, 64);
    endtask

    // receiver stalls for long while sends keep coming
    task automatic test_backpressure();
        set_mesh(2, 4, 16);
        hold_rx = 1'b1;
        fork
            begin
                repeat (400) @(posedge i_clk);
                hold_rx = 1'b0;
            end
        join_none
        test_random(40, 16);
        drain();
        test_random(200, 16);
    endtask

    task automatic test_steady();
        set_mesh(1, 8, 64);
        bursty = 1'b0;
        test_random(570, 64);
    endtask

    initial begin
        lat_cfg = 1; width_cfg = 8; nodes_cfg = 64;
        for (int i = 0; i < mxyrc_pkg::MaxNodes; i++) begin
            cong_lvl[i] = 0; q_head[i] = 0; q_cnt[i] = 0;
        end
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_configs();
        test_backpressure();
        test_steady();
        drain();
        if (err_count == 0) $display("status: pass");
        else $display("status: fail");
        $finish;
    end
endmodule

### files.f
hw/rtl/mxyrc_pkg.sv
hw/rtl/mxyrc_front.sv
hw/rtl/mxyrc_cmdq.sv
hw/rtl/mxyrc_back.sv
hw/rtl/mesh_xy_route_congestion.sv
sim/tb_top.sv
